// ===== src/hss_pkg.sv =====
package hss_pkg;

  // Phase codes of the swing sequence.
  typedef enum logic [3:0] {
    PH_INIT       = 4'd0,
    PH_IDLE       = 4'd1,
    PH_T_SETUP    = 4'd2,
    PH_T_PRESS    = 4'd3,
    PH_T_EXPAND   = 4'd4,
    PH_R_SETUP    = 4'd5,
    PH_R_PRESS    = 4'd6,
    PH_R_EXPAND   = 4'd7,
    PH_R_BRAKE    = 4'd8,
    PH_R_SETTLE   = 4'd9,
    PH_R_COMPLETE = 4'd10
  } phase_t;

  // Request command codes.
  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_CONFIG = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VALVE_TIME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_PRESS_TMO    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T_EXPAND_TMO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_R_PRESS_TMO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R_EXPAND_TMO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_LEVEL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EBRAKE_ANGLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RETRACTED_ANG  = 3'd7;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        now;
    logic signed [31:0] hammer_angle;
    logic signed [31:0] hammer_velocity;
    logic signed [31:0] retract_pressure;
    logic signed [31:0] hammer_energy;
    logic signed [31:0] brake_energy;
    logic signed [31:0] target_throw_angle;
  } hss_in_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       swing_complete;
  } hss_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic advance;
  } dp_stat_t;

endpackage

// ===== src/hammer_swing_sequencer.sv =====
// Hammer swing sequencer.
// An accepted request is held while the phase register takes its transitions (0 to 5),
// one per cycle; its result is registered once none remains and the output is free.
// A new request is taken only after that result is registered, also while it waits.
// Reset (rst, synchronous): phase init, entry time and all configuration registers zero.
module hammer_swing_sequencer #(
  parameter int BRAKE_EXIT_VELOCITY = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hss_pkg::hss_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hss_pkg::hss_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import hss_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencing control.
  hss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // Phase logic, timers and configuration.
  hss_datapath #(
    .BRAKE_EXIT_VELOCITY (BRAKE_EXIT_VELOCITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (dp_cmd),
    .stat      (dp_stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== src/hss_datapath.sv =====
module hss_datapath #(
  parameter int BRAKE_EXIT_VELOCITY = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  hss_pkg::dp_cmd_t          cmd,
  output hss_pkg::dp_stat_t         stat,
  input  hss_pkg::hss_in_t          in_data,
  output hss_pkg::hss_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import hss_pkg::*;

  localparam logic signed [31:0] BrakeExit = signed'(32'(BRAKE_EXIT_VELOCITY));

  // Configuration registers.
  logic [30:0]        valve_change_time;
  logic [30:0]        throw_pressurize_timeout;
  logic [30:0]        throw_expand_timeout;
  logic [30:0]        retract_pressurize_timeout;
  logic [30:0]        retract_expand_timeout;
  logic signed [31:0] retract_fill_level;
  logic signed [31:0] emergency_brake_angle;
  logic signed [31:0] retracted_angle;

  // Sequencer state and the request under work.
  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] entry_time;
  hss_in_t     item;

  logic [30:0] limit;
  logic [31:0] elapsed;
  logic        timed_out;
  logic        throw_hit;
  logic        brake_hit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      valve_change_time          <= '0;
      throw_pressurize_timeout   <= '0;
      throw_expand_timeout       <= '0;
      retract_pressurize_timeout <= '0;
      retract_expand_timeout     <= '0;
      retract_fill_level         <= '0;
      emergency_brake_angle      <= '0;
      retracted_angle            <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VALVE_TIME:    valve_change_time          <= cfg_data[30:0];
        REG_T_PRESS_TMO:   throw_pressurize_timeout   <= cfg_data[30:0];
        REG_T_EXPAND_TMO:  throw_expand_timeout       <= cfg_data[30:0];
        REG_R_PRESS_TMO:   retract_pressurize_timeout <= cfg_data[30:0];
        REG_R_EXPAND_TMO:  retract_expand_timeout     <= cfg_data[30:0];
        REG_FILL_LEVEL:    retract_fill_level         <= signed'(cfg_data);
        REG_EBRAKE_ANGLE:  emergency_brake_angle      <= signed'(cfg_data);
        REG_RETRACTED_ANG: retracted_angle            <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // Timeout of the current phase: one subtract and one compare.
  always_comb begin
    case (phase)
      PH_T_PRESS:  limit = throw_pressurize_timeout;
      PH_T_EXPAND: limit = throw_expand_timeout;
      PH_R_PRESS:  limit = retract_pressurize_timeout;
      PH_R_EXPAND: limit = retract_expand_timeout;
      default:     limit = valve_change_time;
    endcase
  end

  assign elapsed   = item.now - entry_time;
  assign timed_out = elapsed > {1'b0, limit};
  assign throw_hit = item.hammer_angle >= item.target_throw_angle;
  assign brake_hit = item.hammer_angle <= emergency_brake_angle;

  // Next phase for the current request.
  always_comb begin
    phase_next = phase;
    case (item.cmd)
      CMD_CONFIG: begin
        if (phase == PH_INIT) phase_next = PH_IDLE;
      end
      CMD_START: begin
        if (phase == PH_IDLE) phase_next = PH_T_SETUP;
      end
      CMD_UPDATE: begin
        case (phase)
          PH_T_SETUP: begin
            if (timed_out) phase_next = PH_T_PRESS;
          end
          PH_T_PRESS: begin
            if (throw_hit || timed_out) phase_next = PH_T_EXPAND;
          end
          PH_T_EXPAND: begin
            if (throw_hit || timed_out) phase_next = PH_R_SETUP;
          end
          PH_R_SETUP: begin
            if (timed_out) phase_next = PH_R_PRESS;
          end
          PH_R_PRESS: begin
            if (item.retract_pressure >= retract_fill_level || brake_hit || timed_out)
              phase_next = PH_R_EXPAND;
          end
          PH_R_EXPAND: begin
            if (item.hammer_energy >= item.brake_energy || brake_hit || timed_out)
              phase_next = PH_R_BRAKE;
          end
          PH_R_BRAKE: begin
            if (item.hammer_velocity <= BrakeExit || timed_out) phase_next = PH_R_SETTLE;
          end
          PH_R_SETTLE: begin
            if (item.hammer_angle <= retracted_angle || timed_out)
              phase_next = PH_R_COMPLETE;
          end
          PH_R_COMPLETE: begin
            if (timed_out) phase_next = PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign stat.advance = (phase_next != phase);

  // Phase and entry time advance one transition per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_INIT;
      entry_time <= '0;
    end else if (cmd.step) begin
      phase      <= phase_next;
      entry_time <= item.now;
    end
  end

  // Request holding register and result register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.emit) begin
      out_data.phase          <= phase;
      out_data.swing_complete <= (phase == PH_IDLE);
    end
  end

endmodule

// ===== src/hss_ctrl.sv =====
module hss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output hss_pkg::dp_cmd_t  cmd,
  input  hss_pkg::dp_stat_t stat
);
  import hss_pkg::*;

  typedef enum logic {
    S_WAIT,
    S_EVAL
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // Commands to the datapath.
  always_comb begin
    cmd.load = (state == S_WAIT) && in_valid && in_ready;
    cmd.step = (state == S_EVAL) && stat.advance;
    cmd.emit = (state == S_EVAL) && !stat.advance && out_free;
  end

  // State, input ready and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      // The result stays valid until taken; a new one is raised on emit.
      out_valid <= (out_valid && !out_ready) || cmd.emit;
      case (state)
        S_WAIT: begin
          if (in_valid && in_ready) begin
            state    <= S_EVAL;
            in_ready <= 1'b0;
          end
        end
        S_EVAL: begin
          if (!stat.advance && out_free) begin
            state    <= S_WAIT;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_WAIT;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== src/hss_checker.sv =====
module hss_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input hss_pkg::hss_out_t out_data
);
  import hss_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
  else $error("result changed while stalled");

  // The block is busy in the cycle after it takes a request.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
  else $error("request taken while busy");

  // The completion flag matches the idle phase.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.swing_complete == (out_data.phase == 4'(PH_IDLE))))
  else $error("completion flag does not match phase");

  // A result appears only when the block is ready for the next request.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> in_ready)
  else $error("result raised while busy");

endmodule

bind hammer_swing_sequencer hss_checker u_hss_checker (.*);

// ===== tb/sv/hammer_swing_sequencer_checker.sv =====
`timescale 1ns / 1ps

module hammer_swing_sequencer_checker #(
  parameter int BRAKE_EXIT_VELOCITY = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  hss_pkg::hss_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  hss_pkg::hss_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            pending,
  output int                            failures
);
  import hss_pkg::*;

  // Shadow copy of the sequencer: configuration, current phase and its entry time.
  logic [31:0] swing_regs [8];
  phase_t      swing_phase = PH_INIT;
  logic [31:0] swing_entry = '0;

  // Phases expected on the result channel, oldest first.
  hss_out_t    expected_phases [$];
  hss_out_t    oldest;
  int          error_count = 0;

  // True when the time spent in the current phase is strictly past the limit.
  function automatic logic overdue(logic [31:0] now, logic [CFG_IDX_W-1:0] idx);
    logic [31:0] elapsed;
    elapsed = now - swing_entry;
    return elapsed > {1'b0, swing_regs[idx][30:0]};
  endfunction

  // One transition of the phase machine for the sensor values of an update.
  function automatic phase_t phase_after(hss_in_t req);
    logic signed [31:0] angle;
    logic signed [31:0] vel;
    logic signed [31:0] press;
    logic signed [31:0] energy;
    logic signed [31:0] benergy;
    logic signed [31:0] target;
    logic signed [31:0] fill;
    logic signed [31:0] ebrake;
    logic signed [31:0] retracted;
    phase_t             nxt;
    angle     = req.hammer_angle;
    vel       = req.hammer_velocity;
    press     = req.retract_pressure;
    energy    = req.hammer_energy;
    benergy   = req.brake_energy;
    target    = req.target_throw_angle;
    fill      = swing_regs[REG_FILL_LEVEL];
    ebrake    = swing_regs[REG_EBRAKE_ANGLE];
    retracted = swing_regs[REG_RETRACTED_ANG];
    nxt       = swing_phase;
    case (swing_phase)
      PH_T_SETUP: begin
        if (overdue(req.now, REG_VALVE_TIME)) nxt = PH_T_PRESS;
      end
      PH_T_PRESS: begin
        if (angle >= target || overdue(req.now, REG_T_PRESS_TMO)) nxt = PH_T_EXPAND;
      end
      PH_T_EXPAND: begin
        if (angle >= target || overdue(req.now, REG_T_EXPAND_TMO)) nxt = PH_R_SETUP;
      end
      PH_R_SETUP: begin
        if (overdue(req.now, REG_VALVE_TIME)) nxt = PH_R_PRESS;
      end
      PH_R_PRESS: begin
        if (press >= fill || angle <= ebrake || overdue(req.now, REG_R_PRESS_TMO))
          nxt = PH_R_EXPAND;
      end
      PH_R_EXPAND: begin
        if (energy >= benergy || angle <= ebrake || overdue(req.now, REG_R_EXPAND_TMO))
          nxt = PH_R_BRAKE;
      end
      PH_R_BRAKE: begin
        if (vel <= BRAKE_EXIT_VELOCITY || overdue(req.now, REG_VALVE_TIME)) nxt = PH_R_SETTLE;
      end
      PH_R_SETTLE: begin
        if (angle <= retracted || overdue(req.now, REG_VALVE_TIME)) nxt = PH_R_COMPLETE;
      end
      PH_R_COMPLETE: begin
        if (overdue(req.now, REG_VALVE_TIME)) nxt = PH_IDLE;
      end
      default: ;
    endcase
    return nxt;
  endfunction

  // Apply one request to the shadow state and return the phase it reports.
  // An update keeps stepping until the phase no longer moves.
  function automatic hss_out_t step_swing(hss_in_t req);
    hss_out_t res;
    phase_t   nxt;
    logic     moving;
    case (req.cmd)
      CMD_CONFIG: begin
        if (swing_phase == PH_INIT) begin
          swing_phase = PH_IDLE;
          swing_entry = req.now;
        end
      end
      CMD_START: begin
        if (swing_phase == PH_IDLE) begin
          swing_phase = PH_T_SETUP;
          swing_entry = req.now;
        end
      end
      CMD_UPDATE: begin
        moving = 1'b1;
        while (moving) begin
          nxt = phase_after(req);
          if (nxt == swing_phase) begin
            moving = 1'b0;
          end else begin
            swing_phase = nxt;
            swing_entry = req.now;
          end
        end
      end
      default: ;
    endcase
    res.phase          = swing_phase;
    res.swing_complete = (swing_phase == PH_IDLE);
    return res;
  endfunction

  // Compare results first, then predict the new request, then track register writes.
  always @(posedge clk) begin
    if (rst) begin
      swing_phase = PH_INIT;
      swing_entry = '0;
      foreach (swing_regs[i]) swing_regs[i] = '0;
      expected_phases.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_phases.size() == 0) begin
          $error("unexpected result: phase %0d, swing_complete %0d",
                 out_data.phase, out_data.swing_complete);
          error_count++;
        end else begin
          oldest = expected_phases.pop_front();
          if (out_data.phase !== oldest.phase) begin
            $error("phase: expected %0d, actual %0d", oldest.phase, out_data.phase);
            error_count++;
          end
          if (out_data.swing_complete !== oldest.swing_complete) begin
            $error("swing_complete: expected %0d, actual %0d",
                   oldest.swing_complete, out_data.swing_complete);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_phases.push_back(step_swing(in_data));
      if (cfg_we) begin
        if (cfg_index <= REG_R_EXPAND_TMO) swing_regs[cfg_index] = cfg_data & 32'h7FFF_FFFF;
        else swing_regs[cfg_index] = cfg_data;
      end
    end
    pending  <= expected_phases.size();
    failures <= error_count;
  end

endmodule

// ===== tb/sv/hammer_swing_sequencer_test.sv =====
`timescale 1ns / 1ps

module hammer_swing_sequencer_test;
  import hss_pkg::*;

  localparam int         BRAKE_EXIT_VELOCITY = 0;
  localparam int         CYCLE_LIMIT         = 400000;
  localparam int         SETTLE_CYCLES       = 8;
  localparam int         LONG_STALL_CYCLES   = 300;
  localparam logic [1:0] CMD_UNUSED          = 2'd3;

  typedef enum {SET_DIRECTED, SET_SMALL, SET_ZERO, SET_MAX, SET_INVERTED, SET_RANDOM} reg_set_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  hss_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  hss_out_t             out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;
  int                   pending;
  int                   failures;

  // Receiver pattern state.
  logic                 long_stall      = 1'b0;
  logic                 long_stall_done = 1'b0;
  int                   stall_left      = 0;
  int                   mode_left       = 0;
  rx_mode_t             rx_mode         = RX_OPEN;

  // Sender state.
  int                   cycle_count = 0;
  int                   burst_left  = 0;
  int                   tick_step   = 8;
  logic [31:0]          now_tick    = '0;
  logic [31:0]          cfg_val [8];

  always #1 clk = ~clk;

  hammer_swing_sequencer #(
    .BRAKE_EXIT_VELOCITY(BRAKE_EXIT_VELOCITY)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hammer_swing_sequencer_checker #(
    .BRAKE_EXIT_VELOCITY(BRAKE_EXIT_VELOCITY)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (failures)
  );

  // Result channel: one long hold-off on request, otherwise changing stall patterns.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (long_stall && !long_stall_done) begin
      stall_left      <= LONG_STALL_CYCLES;
      long_stall_done <= 1'b1;
      out_ready       <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(5, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("hammer_swing_sequencer: mismatch");
      $finish;
    end
  end

  // Offer one request and wait until it is taken; gaps fall between bursts.
  task automatic send_request(input hss_in_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_fields(input logic [1:0] cmd, input logic [31:0] now,
                             input logic [31:0] angle, input logic [31:0] vel,
                             input logic [31:0] press, input logic [31:0] energy,
                             input logic [31:0] benergy, input logic [31:0] target);
    hss_in_t req;
    req.cmd                = cmd;
    req.now                = now;
    req.hammer_angle       = angle;
    req.hammer_velocity    = vel;
    req.retract_pressure   = press;
    req.hammer_energy      = energy;
    req.brake_energy       = benergy;
    req.target_throw_angle = target;
    send_request(req);
  endtask

  // Stop offering and wait for every outstanding result, then let the block go quiet.
  task automatic hold_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cfg_val[idx];
    @(posedge clk);
  endtask

  // Pick a register set and write every register.
  task automatic load_settings(input reg_set_t kind);
    case (kind)
      SET_DIRECTED: begin
        cfg_val[REG_VALVE_TIME]    = 5;
        cfg_val[REG_T_PRESS_TMO]   = 10;
        cfg_val[REG_T_EXPAND_TMO]  = 10;
        cfg_val[REG_R_PRESS_TMO]   = 10;
        cfg_val[REG_R_EXPAND_TMO]  = 10;
        cfg_val[REG_FILL_LEVEL]    = 100;
        cfg_val[REG_EBRAKE_ANGLE]  = -1000;
        cfg_val[REG_RETRACTED_ANG] = -500;
        tick_step = 8;
      end
      SET_SMALL: begin
        cfg_val[REG_VALVE_TIME]    = $urandom_range(0, 20);
        cfg_val[REG_T_PRESS_TMO]   = $urandom_range(0, 20);
        cfg_val[REG_T_EXPAND_TMO]  = $urandom_range(0, 20);
        cfg_val[REG_R_PRESS_TMO]   = $urandom_range(0, 20);
        cfg_val[REG_R_EXPAND_TMO]  = $urandom_range(0, 20);
        cfg_val[REG_FILL_LEVEL]    = $urandom_range(0, 100) - 32'd50;
        cfg_val[REG_EBRAKE_ANGLE]  = 32'd0 - $urandom_range(50, 150);
        cfg_val[REG_RETRACTED_ANG] = 32'd0 - $urandom_range(0, 50);
        tick_step = 25;
      end
      SET_ZERO: begin
        foreach (cfg_val[i]) cfg_val[i] = '0;
        tick_step = 3;
      end
      SET_MAX: begin
        cfg_val[REG_VALVE_TIME]    = 32'hFFFF_FFFF;
        cfg_val[REG_T_PRESS_TMO]   = 32'hFFFF_FFFF;
        cfg_val[REG_T_EXPAND_TMO]  = 32'hFFFF_FFFF;
        cfg_val[REG_R_PRESS_TMO]   = 32'hFFFF_FFFF;
        cfg_val[REG_R_EXPAND_TMO]  = 32'hFFFF_FFFF;
        cfg_val[REG_FILL_LEVEL]    = 32'h7FFF_FFFF;
        cfg_val[REG_EBRAKE_ANGLE]  = 32'h8000_0000;
        cfg_val[REG_RETRACTED_ANG] = 32'h8000_0000;
        tick_step = 64;
      end
      SET_INVERTED: begin
        // Fill, brake angle and retracted angle conditions always hold, so retracts mostly chain.
        cfg_val[REG_VALVE_TIME]    = 1;
        cfg_val[REG_T_PRESS_TMO]   = 32'h7FFF_FFFF;
        cfg_val[REG_T_EXPAND_TMO]  = 32'h7FFF_FFFF;
        cfg_val[REG_R_PRESS_TMO]   = 32'h7FFF_FFFF;
        cfg_val[REG_R_EXPAND_TMO]  = 32'h7FFF_FFFF;
        cfg_val[REG_FILL_LEVEL]    = 32'h8000_0000;
        cfg_val[REG_EBRAKE_ANGLE]  = 32'h7FFF_FFFF;
        cfg_val[REG_RETRACTED_ANG] = 32'h7FFF_FFFF;
        tick_step = 4;
      end
      default: begin
        cfg_val[REG_VALVE_TIME]    = ($urandom() & 32'h8000_0000) | $urandom_range(0, 40);
        cfg_val[REG_T_PRESS_TMO]   = ($urandom() & 32'h8000_0000) | $urandom_range(0, 40);
        cfg_val[REG_T_EXPAND_TMO]  = ($urandom() & 32'h8000_0000) | $urandom_range(0, 40);
        cfg_val[REG_R_PRESS_TMO]   = ($urandom() & 32'h8000_0000) | $urandom_range(0, 40);
        cfg_val[REG_R_EXPAND_TMO]  = ($urandom() & 32'h8000_0000) | $urandom_range(0, 40);
        cfg_val[REG_FILL_LEVEL]    = $urandom();
        cfg_val[REG_EBRAKE_ANGLE]  = $urandom();
        cfg_val[REG_RETRACTED_ANG] = $urandom();
        tick_step = 60;
      end
    endcase
    write_reg(REG_VALVE_TIME);
    write_reg(REG_T_PRESS_TMO);
    write_reg(REG_T_EXPAND_TMO);
    write_reg(REG_R_PRESS_TMO);
    write_reg(REG_R_EXPAND_TMO);
    write_reg(REG_FILL_LEVEL);
    write_reg(REG_EBRAKE_ANGLE);
    write_reg(REG_RETRACTED_ANG);
    cfg_we <= 1'b0;
  endtask

  // Time mostly creeps forward; now and then it jumps anywhere, backward included.
  function automatic logic [31:0] tick_forward();
    if ($urandom_range(0, 19) == 0) now_tick = $urandom();
    else now_tick = now_tick + $urandom_range(0, tick_step);
    return now_tick;
  endfunction

  // A sensor value close to a threshold, or anything at all.
  function automatic logic [31:0] around(input logic [31:0] level);
    if ($urandom_range(0, 4) == 0) return $urandom();
    return level + $urandom_range(0, 6) - 32'd3;
  endfunction

  task automatic send_cmd(input logic [1:0] cmd);
    send_fields(cmd, tick_forward(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom());
  endtask

  task automatic send_update();
    logic [31:0] target;
    logic [31:0] angle_ref;
    logic [31:0] benergy;
    target = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 200) - 32'd100;
    case ($urandom_range(0, 2))
      0:       angle_ref = target;
      1:       angle_ref = cfg_val[REG_EBRAKE_ANGLE];
      default: angle_ref = cfg_val[REG_RETRACTED_ANG];
    endcase
    benergy = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
    send_fields(CMD_UPDATE, tick_forward(), around(angle_ref), around(BRAKE_EXIT_VELOCITY),
                around(cfg_val[REG_FILL_LEVEL]), around(benergy), benergy, target);
  endtask

  // Swings: a start followed by a run of sensor updates, with some noise mixed in.
  task automatic run_swings(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) send_cmd(CMD_CONFIG);
      else send_cmd(CMD_START);
      sent++;
      repeat ($urandom_range(3, 12)) begin
        case ($urandom_range(0, 19))
          0: send_cmd(CMD_CONFIG);
          1: send_cmd(CMD_UNUSED);
          2: send_fields(2'($urandom_range(0, 3)), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), $urandom());
          3: send_cmd(CMD_START);
          default: send_update();
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    reg_set_t plan [5];
    plan = '{SET_ZERO, SET_MAX, SET_INVERTED, SET_RANDOM, SET_SMALL};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    load_settings(SET_DIRECTED);

    // Commands that do nothing before the first configuration event.
    send_fields(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_START, 5, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_UNUSED, 6, 0, 0, 0, 0, 0, 0);
    // Init to idle, then repeated configuration events and updates in idle.
    send_fields(CMD_CONFIG, 1000, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_CONFIG, 1002, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_UPDATE, 1005, 0, 0, 0, 0, 0, 0);
    // Start a throw; further starts and configuration events are ignored.
    send_fields(CMD_START, 1010, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_START, 1012, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_CONFIG, 1013, 0, 0, 0, 0, 0, 0);
    // Elapsed equal to the timeout does not leave; one more tick does.
    send_fields(CMD_UPDATE, 1015, 32'h8000_0000, 0, 0, 0, 0, 32'h7FFF_FFFF);
    send_fields(CMD_UPDATE, 1016, 0, 0, 0, 0, 0, 50);
    // Target reached: pressurize and expand chain into retract setup.
    send_fields(CMD_UPDATE, 1020, 50, 0, 0, 0, 0, 50);
    // Retract driven by timeouts, then velocity and angle chaining to complete.
    send_fields(CMD_UPDATE, 1026, 0, 0, 99, 0, 0, 0);
    send_fields(CMD_UPDATE, 1037, 0, 0, 99, 5, 10, 0);
    send_fields(CMD_UPDATE, 1048, 0, 1, 99, 5, 10, 0);
    send_fields(CMD_UPDATE, 1050, -500, 0, 99, 5, 10, 0);
    send_fields(CMD_UPDATE, 1056, 0, 0, 0, 0, 0, 0);
    // Wrapping time, extreme values and the emergency brake skip.
    send_fields(CMD_START, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_UPDATE, 32'hFFFF_FFF6, 32'h7FFF_FFFF, 0, 0, 0, 0, 32'h7FFF_FFFF);
    send_fields(CMD_UPDATE, 2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 0);
    send_fields(CMD_UPDATE, 16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hold_for_results();

    // Random swings; the receiver holds off for a long stretch early on.
    now_tick = 32'h100;
    load_settings(SET_SMALL);
    run_swings(40);
    long_stall <= 1'b1;
    run_swings(120);
    foreach (plan[i]) begin
      hold_for_results();
      load_settings(plan[i]);
      run_swings(150);
    end
    hold_for_results();

    if (failures == 0) $display("hammer_swing_sequencer: match");
    else $display("hammer_swing_sequencer: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hss_pkg.sv
src/hss_datapath.sv
src/hss_ctrl.sv
src/hammer_swing_sequencer.sv
src/hss_checker.sv
tb/sv/hammer_swing_sequencer_checker.sv
tb/sv/hammer_swing_sequencer_test.sv
